FILE: src/deq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, codes and transfer types for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH        = 128;
    localparam int DATA_WIDTH   = 32;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int CAP_W        = 8;
    localparam int OCC_W        = 8;
    localparam int CMP_W        = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CAP_RESET    = 128;

    localparam int GROUP        = 8;
    localparam int L1_GROUPS    = (DEPTH + GROUP - 1) / GROUP;
    localparam int L2_GROUPS    = (L1_GROUPS + GROUP - 1) / GROUP;
    localparam int TREE_LATENCY = 2;
    localparam int WAIT_W       = $clog2(TREE_LATENCY + 1);

    typedef logic signed [DATA_WIDTH-1:0] word_t;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        action_t            action;
        logic signed [31:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pop_value;
        status_t            status;
        logic [OCC_W-1:0]   occupancy;
    } out_item_t;

    typedef struct packed {
        logic             shift_in_front;
        logic             shift_to_front;
        logic             write_rear;
        logic [CNT_W-1:0] count;
    } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: src/deq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue cell
// Holds one entry and takes its neighbour's word when the queue shifts.
// ----------------------------------------------------------------------------
module deq_cell (
    input  wire                      clk,
    input  deq_pkg::cell_ctrl_t      ctrl,
    input  wire [deq_pkg::IDX_W-1:0] index,
    input  deq_pkg::word_t           push_value,
    input  deq_pkg::word_t           left_word,
    input  deq_pkg::word_t           right_word,
    output deq_pkg::word_t           word,
    output deq_pkg::word_t           rear_word
);
    import deq_pkg::*;

    word_t            data_reg;
    word_t            data_next;
    logic [CNT_W-1:0] position;

    assign position = CNT_W'(index);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_in_front)
        begin
            data_next = left_word;
        end
        else if (ctrl.shift_to_front)
        begin
            data_next = right_word;
        end
        else if (ctrl.write_rear && (ctrl.count == position))
        begin
            data_next = push_value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign word      = data_reg;
    assign rear_word = (ctrl.count == position + CNT_W'(1)) ? data_reg : '0;

endmodule
`default_nettype wire

FILE: src/deq_rear_tree.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue rear selector
// Registered two-level OR reduction that yields the word of the rear cell.
// ----------------------------------------------------------------------------
module deq_rear_tree (
    input  wire            clk,
    input  deq_pkg::word_t leaf [deq_pkg::DEPTH],
    output deq_pkg::word_t rear
);
    import deq_pkg::*;

    word_t l1_reg  [L1_GROUPS];
    word_t l1_next [L1_GROUPS];
    word_t l2_reg  [L2_GROUPS];
    word_t l2_next [L2_GROUPS];

    always_comb
    begin
        for (int g = 0; g < L1_GROUPS; g++)
        begin
            l1_next[g] = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                if (g * GROUP + k < DEPTH)
                begin
                    l1_next[g] = l1_next[g] | leaf[g * GROUP + k];
                end
            end
        end
    end

    always_comb
    begin
        for (int g = 0; g < L2_GROUPS; g++)
        begin
            l2_next[g] = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                if (g * GROUP + k < L1_GROUPS)
                begin
                    l2_next[g] = l2_next[g] | l1_reg[g * GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        l1_reg <= l1_next;
        l2_reg <= l2_next;
    end

    always_comb
    begin
        rear = '0;
        for (int g = 0; g < L2_GROUPS; g++)
        begin
            rear = rear | l2_reg[g];
        end
    end

endmodule
`default_nettype wire

FILE: src/double_ended_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded queue of signed words with push and pop at either end.
// ----------------------------------------------------------------------------
// An action is taken when start is high and busy is low. Its result appears on
// result in the cycle after the transfer, marked by result_valid, which is high
// for exactly one cycle; the receiver cannot stall it. After each transfer busy
// is raised, and no new action is taken until it falls again. Busy covers the
// two registered levels of the reduction that picks out the rear entry, which
// must settle after every change to the row of cells. The entries sit in a
// row of cells with the front in the first cell; pushes and pops at the front
// shift the whole row by one place. A capacity write takes effect for the next
// action; capacities above the depth act as the depth.
module double_ended_queue_top (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    output logic                     busy,
    input  deq_pkg::in_item_t        item,
    output deq_pkg::out_item_t       result,
    output logic                     result_valid,
    input  wire                      cfg_we,
    input  wire [deq_pkg::CAP_W-1:0] cfg_data
);
    import deq_pkg::*;

    logic [CAP_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [WAIT_W-1:0] wait_reg;
    logic [WAIT_W-1:0] wait_next;
    out_item_t         result_reg;
    out_item_t         result_next;
    logic              result_valid_reg;

    logic              accept;
    logic              full;
    logic              empty;
    logic [CMP_W-1:0]  limit;
    cell_ctrl_t        ctrl;
    word_t             front_word;
    word_t             rear_word;
    word_t             cell_word  [DEPTH];
    word_t             cell_rear  [DEPTH];
    word_t             cell_left  [DEPTH];
    word_t             cell_right [DEPTH];

    assign busy   = (wait_reg != '0);
    assign accept = start && !busy;

    assign limit = (CMP_W'(capacity_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                          : CMP_W'(capacity_reg);
    assign full  = (CMP_W'(count_reg) >= limit);
    assign empty = (count_reg == '0);

    assign front_word = cell_word[0];

    always_comb
    begin
        count_next          = count_reg;
        ctrl.shift_in_front = 1'b0;
        ctrl.shift_to_front = 1'b0;
        ctrl.write_rear     = 1'b0;
        ctrl.count          = count_reg;
        result_next.pop_value = '0;
        result_next.status    = ST_DONE;
        if (accept)
        begin
            unique case (item.action)
                ACT_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        result_next.status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.shift_in_front = 1'b1;
                        count_next          = count_reg + CNT_W'(1);
                    end
                end
                ACT_PUSH_REAR:
                begin
                    if (full)
                    begin
                        result_next.status = ST_FULL;
                    end
                    else
                    begin
                        ctrl.write_rear = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
                ACT_POP_FRONT:
                begin
                    if (empty)
                    begin
                        result_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.shift_to_front   = 1'b1;
                        result_next.pop_value = front_word;
                        count_next            = count_reg - CNT_W'(1);
                    end
                end
                ACT_POP_REAR:
                begin
                    if (empty)
                    begin
                        result_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        result_next.pop_value = rear_word;
                        count_next            = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    result_next.status = ST_DONE;
                end
            endcase
        end
        result_next.occupancy = OCC_W'(count_next);
        wait_next = accept ? WAIT_W'(TREE_LATENCY)
                           : (busy ? wait_reg - WAIT_W'(1) : wait_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg     <= CAP_W'(CAP_RESET);
            count_reg        <= '0;
            wait_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            count_reg        <= count_next;
            wait_reg         <= wait_next;
            result_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign cell_left[i] = item.push_value;
        end
        else
        begin : g_inner
            assign cell_left[i] = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign cell_right[i] = '0;
        end
        else
        begin : g_body
            assign cell_right[i] = cell_word[i+1];
        end

        deq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .index      (IDX_W'(i)),
            .push_value (item.push_value),
            .left_word  (cell_left[i]),
            .right_word (cell_right[i]),
            .word       (cell_word[i]),
            .rear_word  (cell_rear[i])
        );
    end

    deq_rear_tree u_rear_tree (
        .clk  (clk),
        .leaf (cell_rear),
        .rear (rear_word)
    );

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after a transfer");

    a_result_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg == $past(accept))
        else $error("result strobe does not follow a transfer");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("occupancy above depth");

    a_refused_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && (item.action == ACT_PUSH_FRONT || item.action == ACT_PUSH_REAR))
        |=> ($stable(count_reg) && result.status == ST_FULL))
        else $error("refused push changed the occupancy");

    a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !empty && (item.action == ACT_POP_FRONT || item.action == ACT_POP_REAR))
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("successful pop did not reduce the occupancy");
`endif

endmodule
`default_nettype wire
